FILE: design/bgs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgs_pkg
// Shared constants, codes and types of the bilinear grid sampler.
// ----------------------------------------------------------------------------
package bgs_pkg;

   // grid store size
   localparam int MaxCols      = 128;
   localparam int MaxRows      = 128;
   localparam int ColBits      = $clog2(MaxCols);
   localparam int RowBits      = $clog2(MaxRows);
   localparam int IdxBits      = (ColBits > RowBits) ? ColBits : RowBits;
   localparam int CntBits      = IdxBits + 1;

   // four banks split by column and row parity
   localparam int NumBanks     = 4;
   localparam int BankAddrBits = (ColBits - 1) + (RowBits - 1);
   localparam int BankDepth    = 1 << BankAddrBits;

   // axis mapping widths
   localparam int DiffBits     = 33;
   localparam int ProdBits     = 66;
   localparam int CellBits     = 34;
   localparam int WeightBits   = 33;

   localparam int CsrIdxBits   = 3;

   typedef enum logic {
      OpWrite = 1'b0,
      OpQuery = 1'b1
   } op_type;

   typedef enum logic [CsrIdxBits-1:0] {
      CsrColumns     = 3'd0,
      CsrRows        = 3'd1,
      CsrOriginX     = 3'd2,
      CsrOriginZ     = 3'd3,
      CsrInvSpacingX = 3'd4,
      CsrInvSpacingZ = 3'd5
   } csr_index_type;

   typedef logic signed [31:0] height_type;

   // clamped corner indices and fraction of one axis
   typedef struct packed {
      logic [IdxBits-1:0] lo;
      logic [IdxBits-1:0] hi;
      logic [15:0]        frac;
   } axis_sel_type;

   // per-query control handed to the blend pipeline at bank read time
   typedef struct packed {
      logic        query;
      logic        empty;
      logic        col_lo_odd;
      logic        col_hi_odd;
      logic        row_lo_odd;
      logic        row_hi_odd;
      logic [15:0] frac_x;
      logic [15:0] frac_z;
   } blend_ctl_type;

   typedef struct packed {
      logic       valid;
      height_type elevation;
      logic       saturated;
   } result_type;

endpackage

FILE: design/bgs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgs_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module bgs_ram #(
   parameter int Width = 32,
   parameter int Depth = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: design/bgs_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgs_axis
// Maps one query coordinate to grid units: offset, scale, clamp of corners.
// ----------------------------------------------------------------------------
module bgs_axis (
   input  logic                        clock,
   input  logic                        adv,
   input  bgs_pkg::height_type         query,
   input  logic signed [31:0]          origin,
   input  logic [31:0]                 inv_spacing,
   input  logic [bgs_pkg::CntBits-1:0] count,
   output bgs_pkg::axis_sel_type       sel
);
   import bgs_pkg::*;

   logic signed [DiffBits-1:0] diff_in;
   logic signed [DiffBits-1:0] diff_ff;
   logic signed [ProdBits-1:0] prod;
   logic signed [CellBits-1:0] cell_ff;
   logic [15:0]                frac_ff;
   logic signed [CellBits:0]   cell_ext;
   logic signed [CellBits:0]   last;

   function automatic logic [IdxBits-1:0] clamp_idx(input logic signed [CellBits:0] c,
                                                     input logic signed [CellBits:0] top);
      logic [IdxBits-1:0] r;
      if (c < 0) begin
         r = '0;
      end else if (c > top) begin
         r = top[IdxBits-1:0];
      end else begin
         r = c[IdxBits-1:0];
      end
      return r;
   endfunction

   // exact 33-bit difference
   assign diff_in = $signed({query[31], query}) - $signed({origin[31], origin});

   // Q34.32 product; arithmetic shift gives the floored cell for both signs
   assign prod = diff_ff * $signed({1'b0, inv_spacing});

   always_ff @(posedge clock) begin
      if (adv) begin
         diff_ff <= diff_in;
         cell_ff <= prod[ProdBits-1:32];
         frac_ff <= prod[31:16];
      end
   end

   assign cell_ext = {cell_ff[CellBits-1], cell_ff};
   assign last     = $signed({{(CellBits + 1 - CntBits){1'b0}}, count}) - 1;

   assign sel.lo   = clamp_idx(cell_ext, last);
   assign sel.hi   = clamp_idx(cell_ext + 1, last);
   assign sel.frac = frac_ff;

endmodule

FILE: design/bgs_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgs_blend
// Weights the four corner heights, sums, rounds and saturates to Q16.16.
// ----------------------------------------------------------------------------
module bgs_blend (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  bgs_pkg::blend_ctl_type ctl,
   input  bgs_pkg::height_type    bank_data [bgs_pkg::NumBanks],
   output bgs_pkg::result_type    res
);
   import bgs_pkg::*;

   // corner k: bit 0 selects the high column, bit 1 the high row
   logic [16:0]               wx [2];
   logic [16:0]               wz [2];
   logic [2*17-1:0]           wprod [NumBanks];
   logic [WeightBits-1:0]     w_ff [NumBanks];
   logic                      c_valid_ff, c_empty_ff;
   logic                      c_col_lo_odd_ff, c_col_hi_odd_ff;
   logic                      c_row_lo_odd_ff, c_row_hi_odd_ff;

   logic signed [65:0]        hprod [NumBanks];
   logic signed [63:0]        p_ff [NumBanks];
   logic                      d_valid_ff, d_empty_ff;

   logic signed [63:0]        sum_in;
   logic signed [63:0]        e_sum_ff;
   logic                      e_valid_ff, e_empty_ff;

   logic signed [64:0]        rnd;
   logic signed [32:0]        whole;
   logic                      sat;

   always_comb begin
      wx[0] = 17'h10000 - {1'b0, ctl.frac_x};
      wx[1] = {1'b0, ctl.frac_x};
      wz[0] = 17'h10000 - {1'b0, ctl.frac_z};
      wz[1] = {1'b0, ctl.frac_z};
      for (int k = 0; k < NumBanks; k++) begin
         wprod[k] = wx[k % 2] * wz[k / 2];
      end
   end

   // corner heights come from the bank matching each corner's parity
   always_comb begin
      for (int k = 0; k < NumBanks; k++) begin
         hprod[k] = bank_data[{((k / 2) != 0) ? c_row_hi_odd_ff : c_row_lo_odd_ff,
                               ((k % 2) != 0) ? c_col_hi_odd_ff : c_col_lo_odd_ff}]
                    * $signed({1'b0, w_ff[k]});
      end
   end

   assign sum_in = (p_ff[0] + p_ff[1]) + (p_ff[2] + p_ff[3]);

   // round half up, then clip
   assign rnd   = {e_sum_ff[63], e_sum_ff} + 65'sh0_8000_0000;
   assign whole = rnd[64:32];
   assign sat   = whole[32] ^ whole[31];

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else if (adv) begin
         c_valid_ff <= ctl.query;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_empty_ff      <= ctl.empty;
         c_col_lo_odd_ff <= ctl.col_lo_odd;
         c_col_hi_odd_ff <= ctl.col_hi_odd;
         c_row_lo_odd_ff <= ctl.row_lo_odd;
         c_row_hi_odd_ff <= ctl.row_hi_odd;
         for (int k = 0; k < NumBanks; k++) begin
            w_ff[k] <= wprod[k][WeightBits-1:0];
            p_ff[k] <= hprod[k][63:0];
         end
         d_empty_ff <= c_empty_ff;
         e_empty_ff <= d_empty_ff;
         e_sum_ff   <= sum_in;
      end
   end

   always_comb begin
      res.valid = e_valid_ff;
      if (e_empty_ff) begin
         res.elevation = '0;
         res.saturated = 1'b0;
      end else if (sat) begin
         res.elevation = whole[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         res.saturated = 1'b1;
      end else begin
         res.elevation = whole[31:0];
         res.saturated = 1'b0;
      end
   end

endmodule

FILE: design/bilinear_grid_sampler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_grid_sampler_core
// Height grid in four parity banks; bilinear point queries, Q16.16.
// ----------------------------------------------------------------------------
//
//  channel  | ports                          | direction | handshake
//  ---------+--------------------------------+-----------+-------------------
//  request  | req_operation .. req_query_z   | in        | req_valid/req_stall
//  response | rsp_elevation, rsp_saturated   | out       | rsp_valid/rsp_stall
//  csr      | csr_index, csr_data            | in        | csr_valid/csr_ready
//
//  One transaction per cycle in steady state, while req_stall is low. A query
//  passes offset, multiply, bank read, weighting, sum and output registers.
//  Cell writes flow down the same pipe and hit the banks at the bank read
//  stage, so later queries always see earlier writes with no forwarding.
//  Reset is synchronous; the grid itself is not cleared and has no clearing
//  pass: cells read before being written return undefined heights.
//  Output register plus one skid entry: req_stall rises only once both hold
//  results, and the whole pipe freezes until the skid entry drains.
// ----------------------------------------------------------------------------
module bilinear_grid_sampler_core (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_operation,
   input  logic [6:0]                     req_cell_col,
   input  logic [6:0]                     req_cell_row,
   input  logic signed [31:0]             req_cell_height,
   input  logic signed [31:0]             req_query_x,
   input  logic signed [31:0]             req_query_z,

   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [31:0]             rsp_elevation,
   output logic                           rsp_saturated,

   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bgs_pkg::CsrIdxBits-1:0] csr_index,
   input  logic [31:0]                    csr_data
);
   import bgs_pkg::*;

   // configuration registers
   logic [7:0]         columns_ff;
   logic [7:0]         rows_ff;
   logic signed [31:0] origin_x_ff;
   logic signed [31:0] origin_z_ff;
   logic [31:0]        inv_spacing_x_ff;
   logic [31:0]        inv_spacing_z_ff;

   logic [CntBits-1:0] ncol, nrow;

   // pipe advance: everything moves unless the skid entry is occupied
   logic adv;

   // stage A (after acceptance) and stage B (after the multiply)
   logic               a_valid_ff, b_valid_ff;
   op_type             a_op_ff, b_op_ff;
   logic [6:0]         a_col_ff, b_col_ff;
   logic [6:0]         a_row_ff, b_row_ff;
   height_type         a_height_ff, b_height_ff;

   axis_sel_type       x_sel, z_sel;
   logic [ColBits-1:0] col_lo, col_hi, wr_col;
   logic [RowBits-1:0] row_lo, row_hi, wr_row;
   logic               b_query, b_write, wr_in_store;

   height_type         bank_rdata [NumBanks];
   blend_ctl_type      blend_ctl;
   result_type         blend_res;

   // response register and skid entry
   logic               rsp_valid_ff, rsp_valid_in;
   height_type         rsp_elev_ff, rsp_elev_in;
   logic               rsp_sat_ff, rsp_sat_in;
   logic               skid_valid_ff, skid_valid_in;
   height_type         skid_elev_ff, skid_elev_in;
   logic               skid_sat_ff, skid_sat_in;
   logic               out_take;

   // ---------------------------------------------------------------- csr
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff       <= '0;
         rows_ff          <= '0;
         origin_x_ff      <= '0;
         origin_z_ff      <= '0;
         inv_spacing_x_ff <= 32'h0001_0000;
         inv_spacing_z_ff <= 32'h0001_0000;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CsrColumns:     columns_ff       <= csr_data[7:0];
            CsrRows:        rows_ff          <= csr_data[7:0];
            CsrOriginX:     origin_x_ff      <= csr_data;
            CsrOriginZ:     origin_z_ff      <= csr_data;
            CsrInvSpacingX: inv_spacing_x_ff <= csr_data;
            CsrInvSpacingZ: inv_spacing_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // sizes beyond the store count as the store size
   assign ncol = (32'(columns_ff) > 32'(MaxCols)) ? CntBits'(MaxCols) : CntBits'(columns_ff);
   assign nrow = (32'(rows_ff) > 32'(MaxRows)) ? CntBits'(MaxRows) : CntBits'(rows_ff);

   // ---------------------------------------------------------- pipe front
   assign adv       = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_op_ff     <= op_type'(req_operation);
         a_col_ff    <= req_cell_col;
         a_row_ff    <= req_cell_row;
         a_height_ff <= req_cell_height;
         b_op_ff     <= a_op_ff;
         b_col_ff    <= a_col_ff;
         b_row_ff    <= a_row_ff;
         b_height_ff <= a_height_ff;
      end
   end

   bgs_axis u_axis_x (
      .clock       (clock),
      .adv         (adv),
      .query       (req_query_x),
      .origin      (origin_x_ff),
      .inv_spacing (inv_spacing_x_ff),
      .count       (ncol),
      .sel         (x_sel)
   );

   bgs_axis u_axis_z (
      .clock       (clock),
      .adv         (adv),
      .query       (req_query_z),
      .origin      (origin_z_ff),
      .inv_spacing (inv_spacing_z_ff),
      .count       (nrow),
      .sel         (z_sel)
   );

   // ------------------------------------------------------------ banks
   assign col_lo = x_sel.lo[ColBits-1:0];
   assign col_hi = x_sel.hi[ColBits-1:0];
   assign row_lo = z_sel.lo[RowBits-1:0];
   assign row_hi = z_sel.hi[RowBits-1:0];

   assign b_query     = b_valid_ff && (b_op_ff == OpQuery);
   assign b_write     = b_valid_ff && (b_op_ff == OpWrite);
   assign wr_col      = ColBits'(b_col_ff);
   assign wr_row      = RowBits'(b_row_ff);
   assign wr_in_store = (32'(b_col_ff) < 32'(MaxCols)) && (32'(b_row_ff) < 32'(MaxRows));

   // Bank {row parity, column parity}. The two columns of a query are either
   // neighbors (one in each parity) or the same clamped column; likewise rows.
   for (genvar b = 0; b < NumBanks; b++) begin : g_bank
      localparam logic ColOdd = ((b & 1) != 0);
      localparam logic RowOdd = ((b & 2) != 0);

      logic [ColBits-1:0]      rd_col;
      logic [RowBits-1:0]      rd_row;
      logic [BankAddrBits-1:0] addr;
      logic                    we;

      assign rd_col = (col_lo[0] == ColOdd) ? col_lo : col_hi;
      assign rd_row = (row_lo[0] == RowOdd) ? row_lo : row_hi;
      assign we     = adv && b_write && wr_in_store
                      && (wr_col[0] == ColOdd) && (wr_row[0] == RowOdd);
      assign addr   = b_write ? {wr_row[RowBits-1:1], wr_col[ColBits-1:1]}
                              : {rd_row[RowBits-1:1], rd_col[ColBits-1:1]};

      bgs_ram #(
         .Width (32),
         .Depth (BankDepth)
      ) u_ram (
         .clock (clock),
         .we    (we),
         .re    (adv && b_query),
         .addr  (addr),
         .wdata (b_height_ff),
         .rdata (bank_rdata[b])
      );
   end

   // ------------------------------------------------------------ blend
   assign blend_ctl.query      = b_query;
   assign blend_ctl.empty      = (ncol == '0) || (nrow == '0);
   assign blend_ctl.col_lo_odd = col_lo[0];
   assign blend_ctl.col_hi_odd = col_hi[0];
   assign blend_ctl.row_lo_odd = row_lo[0];
   assign blend_ctl.row_hi_odd = row_hi[0];
   assign blend_ctl.frac_x     = x_sel.frac;
   assign blend_ctl.frac_z     = z_sel.frac;

   bgs_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .ctl       (blend_ctl),
      .bank_data (bank_rdata),
      .res       (blend_res)
   );

   // --------------------------------------------------- output and skid
   assign out_take = rsp_valid_ff && !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_elev_in   = rsp_elev_ff;
      rsp_sat_in    = rsp_sat_ff;
      skid_valid_in = skid_valid_ff;
      skid_elev_in  = skid_elev_ff;
      skid_sat_in   = skid_sat_ff;
      if (skid_valid_ff) begin
         // pipe is frozen; drain skid into the output register
         if (out_take) begin
            rsp_elev_in   = skid_elev_ff;
            rsp_sat_in    = skid_sat_ff;
            skid_valid_in = 1'b0;
         end
      end else if (blend_res.valid) begin
         if (!rsp_valid_ff || out_take) begin
            rsp_valid_in = 1'b1;
            rsp_elev_in  = blend_res.elevation;
            rsp_sat_in   = blend_res.saturated;
         end else begin
            skid_valid_in = 1'b1;
            skid_elev_in  = blend_res.elevation;
            skid_sat_in   = blend_res.saturated;
         end
      end else if (out_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      rsp_elev_ff  <= rsp_elev_in;
      rsp_sat_ff   <= rsp_sat_in;
      skid_elev_ff <= skid_elev_in;
      skid_sat_ff  <= skid_sat_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_elevation = rsp_elev_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule

FILE: bench/bilinear_grid_sampler_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_grid_sampler_core_tb
// Self-checking bench for the bilinear height-grid sampler.
// A bit-exact predictor mirrors the grid store and the CSR settings and works
// out the elevation of every accepted query. Responses are matched in order.
// Directed transactions cover the empty grid, height and coordinate extremes
// and the axis mapping extremes. Random phases follow, each with its own grid
// shape, origin and spacing. The sender runs in bursts and the receiver stalls
// in changing styles.
// ----------------------------------------------------------------------------
module bilinear_grid_sampler_core_tb;
   import bgs_pkg::*;

   localparam int HalfPeriod  = 6;
   localparam int ResetCycles = 6;
   localparam int PipeSettle  = 8;     // pipe depth is five, plus margin
   localparam int IdleLimit   = 2000;  // cycles with no transaction at all
   localparam int NumPhases   = 12;
   localparam int PhaseItems  = 90;
   localparam int StoreWords  = MaxCols * MaxRows;

   typedef struct packed {
      op_type      op;
      logic [6:0]  col;
      logic [6:0]  row;
      height_type  height;
      logic [31:0] qx;
      logic [31:0] qz;
   } grid_req_type;

   typedef struct packed {
      height_type elevation;
      logic       saturated;
   } elevation_rsp_type;

   // ---------------------------------------------------------------------
   // clock and DUT ports
   // ---------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset;

   logic                  req_valid;
   logic                  req_stall;
   logic                  req_operation;
   logic [6:0]            req_cell_col;
   logic [6:0]            req_cell_row;
   logic signed [31:0]    req_cell_height;
   logic signed [31:0]    req_query_x;
   logic signed [31:0]    req_query_z;

   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic signed [31:0]    rsp_elevation;
   logic                  rsp_saturated;

   logic                  csr_valid;
   logic                  csr_ready;
   logic [CsrIdxBits-1:0] csr_index;
   logic [31:0]           csr_data;

   always #HalfPeriod clock = ~clock;

   bilinear_grid_sampler_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_cell_col    (req_cell_col),
      .req_cell_row    (req_cell_row),
      .req_cell_height (req_cell_height),
      .req_query_x     (req_query_x),
      .req_query_z     (req_query_z),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_elevation   (rsp_elevation),
      .rsp_saturated   (rsp_saturated),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   // ---------------------------------------------------------------------
   // predictor state: shadow grid and shadow CSRs
   // ---------------------------------------------------------------------
   height_type  grid_heights [StoreWords];
   bit          grid_written [StoreWords];   // queries never touch unwritten cells
   logic [7:0]  model_columns;
   logic [7:0]  model_rows;
   logic [31:0] model_origin_x;
   logic [31:0] model_origin_z;
   logic [31:0] model_inv_x;
   logic [31:0] model_inv_z;

   elevation_rsp_type pending_elevations [$];
   int                fail_count = 0;

   // sender bookkeeping: req_active mirrors the last value driven on req_valid
   bit req_active = 1'b0;
   int burst_left = 0;

   // ---------------------------------------------------------------------
   // axis mapping: (q - origin) * inv, floored to Q16.16 grid units, then
   // split into an integer cell and a 16-bit fraction
   // ---------------------------------------------------------------------
   function automatic void map_to_grid(input logic [31:0] q, input logic [31:0] org,
                                       input logic [31:0] inv,
                                       output longint grid_cell, output logic [15:0] frac);
      longint          diff;
      longint unsigned mag;
      longint unsigned prod;
      longint unsigned coord;
      diff = longint'($signed(q)) - longint'($signed(org));
      mag  = (diff < 0) ? -diff : diff;
      prod = mag * {32'd0, inv};
      if (diff >= 0) begin
         coord     = prod >> 16;
         grid_cell = longint'(coord >> 16);
         frac      = coord[15:0];
      end else begin
         // magnitude of the floored negative coordinate
         coord     = (prod + 64'hFFFF) >> 16;
         grid_cell = -longint'((coord + 64'hFFFF) >> 16);
         frac      = 16'h0 - coord[15:0];
      end
   endfunction

   function automatic int clamp_index(input longint c, input int n);
      if (c < 0)
         return 0;
      if (c > n - 1)
         return n - 1;
      return int'(c);
   endfunction

   function automatic longint height_at(input int c, input int r);
      return longint'(grid_heights[r * MaxCols + c]);
   endfunction

   function automatic int grid_cols_in_use();
      return (model_columns > MaxCols) ? MaxCols : int'(model_columns);
   endfunction

   function automatic int grid_rows_in_use();
      return (model_rows > MaxRows) ? MaxRows : int'(model_rows);
   endfunction

   function automatic elevation_rsp_type predict_elevation(input logic [31:0] qx,
                                                           input logic [31:0] qz);
      elevation_rsp_type r;
      int              ncol;
      int              nrow;
      longint          cx;
      longint          cz;
      logic [15:0]     fx;
      logic [15:0]     fz;
      int              c0, c1, r0, r1;
      longint          wx0, wx1, wz0, wz1;
      longint          sum;
      longint          res;
      longint unsigned biased;
      ncol = grid_cols_in_use();
      nrow = grid_rows_in_use();
      r.elevation = '0;
      r.saturated = 1'b0;
      if (ncol == 0 || nrow == 0)
         return r;
      map_to_grid(qx, model_origin_x, model_inv_x, cx, fx);
      map_to_grid(qz, model_origin_z, model_inv_z, cz, fz);
      c0 = clamp_index(cx, ncol);
      c1 = clamp_index(cx + 1, ncol);
      r0 = clamp_index(cz, nrow);
      r1 = clamp_index(cz + 1, nrow);
      wx1 = fx;
      wx0 = 65536 - wx1;
      wz1 = fz;
      wz0 = 65536 - wz1;
      // weights add up to 2^32, so the sum fits 64 bits exactly
      sum = height_at(c0, r0) * (wx0 * wz0) + height_at(c1, r0) * (wx1 * wz0)
          + height_at(c0, r1) * (wx0 * wz1) + height_at(c1, r1) * (wx1 * wz1);
      // round half up through an offset-binary shift
      biased = sum + 64'h8000_0000_8000_0000;
      res    = longint'(biased >> 32) - 64'sh8000_0000;
      if (res > 64'sh7FFF_FFFF) begin
         res         = 64'sh7FFF_FFFF;
         r.saturated = 1'b1;
      end else if (res < -64'sh8000_0000) begin
         res         = -64'sh8000_0000;
         r.saturated = 1'b1;
      end
      r.elevation = res[31:0];
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // transaction builders
   // ---------------------------------------------------------------------
   function automatic height_type random_height();
      case ($urandom_range(0, 7))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic grid_req_type make_write(input logic [6:0] c, input logic [6:0] r,
                                               input height_type h);
      grid_req_type t;
      t.op     = OpWrite;
      t.col    = c;
      t.row    = r;
      t.height = h;
      t.qx     = $urandom;   // ignored on a write
      t.qz     = $urandom;
      return t;
   endfunction

   function automatic grid_req_type make_query(input logic [31:0] qx,
                                               input logic [31:0] qz);
      grid_req_type t;
      t.op     = OpQuery;
      t.col    = 7'($urandom);   // cell fields ignored on a query
      t.row    = 7'($urandom);
      t.height = $urandom;
      t.qx     = qx;
      t.qz     = qz;
      return t;
   endfunction

   // world coordinate from one cell below the grid to two cells past its end
   function automatic logic [31:0] near_grid_coord(input logic [31:0] org,
                                                   input logic [31:0] inv, input int n);
      longint unsigned cell_w;
      longint unsigned span;
      longint unsigned pick;
      if (inv == 0)
         return $urandom;
      cell_w = (64'd1 << 32) / inv;
      span   = cell_w * (n + 3);
      pick   = {$urandom, $urandom} % span;
      return org + 32'(pick - cell_w);
   endfunction

   // ---------------------------------------------------------------------
   // request driver: one transaction, then maybe a gap between bursts
   // ---------------------------------------------------------------------
   task automatic issue_request(input grid_req_type t);
      int gap;
      req_valid       <= 1'b1;
      req_operation   <= t.op;
      req_cell_col    <= t.col;
      req_cell_row    <= t.row;
      req_cell_height <= t.height;
      req_query_x     <= t.qx;
      req_query_z     <= t.qz;
      req_active       = 1'b1;
      do @(posedge clock); while (req_stall);
      if (t.op == OpWrite) begin
         grid_heights[t.row * MaxCols + t.col] = t.height;
         grid_written[t.row * MaxCols + t.col] = 1'b1;
      end else begin
         pending_elevations.insert(pending_elevations.size(),
                                   predict_elevation(t.qx, t.qz));
      end
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap        = $urandom_range(1, 6);
         req_valid <= 1'b0;
         req_active = 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
   endtask

   // hold off the sender until every outstanding query has answered and any
   // trailing cell writes have left the pipe
   task automatic drain_pipeline();
      if (req_active) begin
         req_valid <= 1'b0;
         req_active = 1'b0;
      end
      while (pending_elevations.size() != 0) @(posedge clock);
      repeat (PipeSettle) @(posedge clock);
   endtask

   // csr_valid stays high across back-to-back writes; configure_grid drops it
   task automatic write_register(input csr_index_type idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CsrColumns:     model_columns  = data[7:0];
         CsrRows:        model_rows     = data[7:0];
         CsrOriginX:     model_origin_x = data;
         CsrOriginZ:     model_origin_z = data;
         CsrInvSpacingX: model_inv_x    = data;
         CsrInvSpacingZ: model_inv_z    = data;
         default: ;
      endcase
   endtask

   task automatic configure_grid(input logic [7:0] cols, input logic [7:0] rows,
                                 input logic [31:0] ox, input logic [31:0] oz,
                                 input logic [31:0] ix, input logic [31:0] iz);
      drain_pipeline();
      write_register(CsrColumns, {24'd0, cols});
      write_register(CsrRows, {24'd0, rows});
      write_register(CsrOriginX, ox);
      write_register(CsrOriginZ, oz);
      write_register(CsrInvSpacingX, ix);
      write_register(CsrInvSpacingZ, iz);
      csr_valid <= 1'b0;
   endtask

   // every cell a query can reach gets written before the first query
   task automatic fill_grid_in_use();
      int c;
      int r;
      for (r = 0; r < grid_rows_in_use(); r++)
         for (c = 0; c < grid_cols_in_use(); c++)
            if (!grid_written[r * MaxCols + c])
               issue_request(make_write(c[6:0], r[6:0], random_height()));
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // reset settings describe an empty grid; a zero on either axis keeps it
   // empty whatever the other axis says
   task automatic test_empty_grid();
      issue_request(make_query(32'h0, 32'h0));
      issue_request(make_query(32'h7FFF_FFFF, 32'h8000_0000));
      configure_grid(8'd5, 8'd0, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000);
      issue_request(make_query($urandom, $urandom));
      configure_grid(8'd0, 8'd200, $urandom, $urandom, $urandom, $urandom);
      issue_request(make_query($urandom, $urandom));
   endtask

   // 2x2 grid at unit spacing: height extremes in the corners, points in the
   // middle, on a corner, and clamped from both sides
   task automatic test_corner_extremes();
      configure_grid(8'd2, 8'd2, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000);
      issue_request(make_write(7'd0, 7'd0, 32'sh7FFF_FFFF));
      issue_request(make_write(7'd1, 7'd0, 32'sh8000_0000));
      issue_request(make_write(7'd0, 7'd1, 32'sh0000_0000));
      issue_request(make_write(7'd1, 7'd1, 32'shFFFF_FFFF));
      // far corner of the store, outside the grid in use for now
      issue_request(make_write(7'd127, 7'd127, random_height()));
      issue_request(make_query(32'h0000_8000, 32'h0000_8000));
      issue_request(make_query(32'h0000_0000, 32'h0000_0000));
      issue_request(make_query(32'h0001_0000, 32'h0001_0000));
      issue_request(make_query(32'hFFFD_0000, 32'h0000_0000));
      issue_request(make_query(32'h7FFF_FFFF, 32'h7FFF_FFFF));
      issue_request(make_query(32'h8000_0000, 32'h0001_8000));
   endtask

   // largest positive and negative offsets against the widest and the zero
   // reciprocal spacing
   task automatic test_axis_extremes();
      configure_grid(8'd2, 8'd2, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0);
      issue_request(make_query(32'h7FFF_FFFF, 32'h8000_0000));
      issue_request(make_query(32'h8000_0000, 32'h7FFF_FFFF));
      configure_grid(8'd2, 8'd2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000,
                     32'hFFFF_FFFF);
      issue_request(make_query(32'h8000_0000, 32'h7FFF_FFFF));
      issue_request(make_query(32'h7FFF_FFFF, 32'h8000_0001));
      issue_request(make_query(32'h0001_2345, 32'hFFFF_0000));
   endtask

   // random phases: each picks a grid shape and mapping, fills the grid in
   // use, then mixes queries (mostly near the grid) with cell writes
   task automatic test_random_phases();
      int          phase;
      int          n;
      int          kind;
      logic [7:0]  cols;
      logic [7:0]  rows;
      logic [31:0] org [2];
      logic [31:0] inv [2];
      logic [31:0] qx;
      logic [31:0] qz;
      int          axis;
      for (phase = 0; phase < NumPhases; phase++) begin
         // first four phases walk every shape once, the rest are random
         kind = (phase < 4) ? phase : $urandom_range(0, 3);
         case (kind)
            0: begin
               cols = 8'($urandom_range(1, 8));
               rows = 8'($urandom_range(1, 8));
            end
            1: begin   // wide, possibly beyond the store
               cols = $urandom_range(0, 1) ? 8'd128 : 8'd255;
               rows = 8'($urandom_range(1, 2));
            end
            2: begin   // tall, possibly beyond the store
               cols = 8'($urandom_range(1, 2));
               rows = $urandom_range(0, 1) ? 8'd128 : 8'd255;
            end
            default: begin
               if ($urandom_range(0, 1)) begin
                  cols = 8'd0;
                  rows = 8'($urandom_range(0, 255));
               end else begin
                  cols = 8'($urandom_range(0, 255));
                  rows = 8'd0;
               end
            end
         endcase
         for (axis = 0; axis < 2; axis++) begin
            org[axis] = $urandom_range(0, 1) ? $urandom
                                             : $urandom_range(0, 32'h4_0000) - 32'h2_0000;
            case ($urandom_range(0, 6))
               0:       inv[axis] = 32'h0001_0000;
               1:       inv[axis] = 32'h0000_8000;
               2:       inv[axis] = 32'h0002_0000;
               3:       inv[axis] = $urandom_range(32'h1000, 32'h10_0000);
               4:       inv[axis] = 32'h0;
               5:       inv[axis] = 32'hFFFF_FFFF;
               default: inv[axis] = $urandom;
            endcase
         end
         configure_grid(cols, rows, org[0], org[1], inv[0], inv[1]);
         fill_grid_in_use();
         for (n = 0; n < PhaseItems; n++) begin
            if ($urandom_range(0, 4) == 0) begin
               if ($urandom_range(0, 1) && grid_cols_in_use() != 0 && grid_rows_in_use() != 0)
                  issue_request(make_write(7'($urandom_range(0, grid_cols_in_use() - 1)),
                                           7'($urandom_range(0, grid_rows_in_use() - 1)),
                                           random_height()));
               else
                  issue_request(make_write(7'($urandom), 7'($urandom), random_height()));
            end else begin
               qx = ($urandom_range(0, 3) == 0) ? $urandom
                    : near_grid_coord(model_origin_x, model_inv_x, grid_cols_in_use());
               qz = ($urandom_range(0, 3) == 0) ? $urandom
                    : near_grid_coord(model_origin_z, model_inv_z, grid_rows_in_use());
               issue_request(make_query(qx, qz));
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // response checker: in-order match against the predicted elevations
   // ---------------------------------------------------------------------
   elevation_rsp_type rsp_want;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_elevations.size() == 0) begin
            $error("response with no query outstanding: elevation %0d saturated %0b",
                   rsp_elevation, rsp_saturated);
            fail_count++;
         end else begin
            rsp_want = pending_elevations.pop_front();
            if (rsp_elevation !== rsp_want.elevation) begin
               $error("elevation mismatch: expected %0d actual %0d",
                      rsp_want.elevation, rsp_elevation);
               fail_count++;
            end
            if (rsp_saturated !== rsp_want.saturated) begin
               $error("saturated mismatch: expected %0b actual %0b",
                      rsp_want.saturated, rsp_saturated);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // receiver stall pattern: styles switch from time to time between
   // never stalling, scattered stalls, and long stall runs
   // ---------------------------------------------------------------------
   int stall_style      = 0;
   int stall_phase_left = 0;

   always @(posedge clock) begin
      if (stall_phase_left == 0) begin
         stall_style      <= $urandom_range(0, 2);
         stall_phase_left <= $urandom_range(40, 200);
      end else begin
         stall_phase_left <= stall_phase_left - 1;
      end
      case (stall_style)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 99) < 35);
         default: rsp_stall <= ($urandom_range(0, 7) == 0) ? ~rsp_stall : rsp_stall;
      endcase
   end

   // ---------------------------------------------------------------------
   // watchdog: any transaction on any channel counts as progress
   // ---------------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_operation   <= OpWrite;
      req_cell_col    <= '0;
      req_cell_row    <= '0;
      req_cell_height <= '0;
      req_query_x     <= '0;
      req_query_z     <= '0;
      csr_valid       <= 1'b0;
      csr_index       <= CsrColumns;
      csr_data        <= '0;
      // shadow CSRs start at their reset values
      model_columns  = 8'd0;
      model_rows     = 8'd0;
      model_origin_x = 32'h0;
      model_origin_z = 32'h0;
      model_inv_x    = 32'h0001_0000;
      model_inv_z    = 32'h0001_0000;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_grid();
      test_corner_extremes();
      test_axis_extremes();
      test_random_phases();

      drain_pipeline();
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: files.f
design/bgs_pkg.sv
design/bgs_ram.sv
design/bgs_axis.sv
design/bgs_blend.sv
design/bilinear_grid_sampler_core.sv
bench/bilinear_grid_sampler_core_tb.sv
